// ===== rtl/b64_pkg.sv =====
// Shared types, constants and alphabet functions for the base64 codec.
`timescale 1ns / 1ps

package b64_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [7:0] PAD_CHAR   = 8'h3D;  // '='
  localparam logic [0:0] MODE_ENC   = 1'b0;
  localparam logic [0:0] MODE_DEC   = 1'b1;

  // One queued group: everything the back end needs to emit its results.
  typedef struct packed {
    logic        enc;       // encode group (characters) vs decode group (bytes)
    logic [23:0] bits;      // assembled group
    logic [1:0]  nres_m1;   // number of results minus one
    logic [2:0]  nch;       // encode: alphabet characters before padding
    logic        last;      // final group of the message
    logic        err;       // error flag carried on every result
  } b64_job_t;

  // Sextet to alphabet character.
  function automatic logic [7:0] b64_enc_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26)      b64_enc_char = w + 8'd65;          // 'A'
    else if (v < 6'd52) b64_enc_char = w + 8'd71;          // 'a' - 26
    else if (v < 6'd62) b64_enc_char = w - 8'd4;           // '0' - 52
    else if (v == 6'd62) b64_enc_char = 8'h2B;             // '+'
    else                 b64_enc_char = 8'h2F;             // '/'
  endfunction

  // Character to {invalid, sextet}; invalid characters give sextet 0.
  function automatic logic [6:0] b64_dec_char(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      t = c - 8'h41;
      b64_dec_char = {1'b0, t[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      t = c - 8'h47;
      b64_dec_char = {1'b0, t[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c + 8'h04;
      b64_dec_char = {1'b0, t[5:0]};
    end else if (c == 8'h2B) begin
      b64_dec_char = {1'b0, 6'd62};
    end else if (c == 8'h2F) begin
      b64_dec_char = {1'b0, 6'd63};
    end else begin
      b64_dec_char = {1'b1, 6'd0};
    end
  endfunction

endpackage

// ===== rtl/base64_codec.sv =====
// Top level of the streaming base64 codec (standard alphabet, encode/decode by mode).
`timescale 1ns / 1ps

// Channel   Direction  Fields (low bit up)
// in_*      slave      tdata[7:0] data_byte, tlast last_item
// out_*     master     tdata[7:0] out_value, tlast out_last, tuser[0] error
// cfg_*     write      cfg_wdata[0] mode (0 encode, 1 decode)
//
// The front end folds every input transfer into the group
// and pushes a finished group into a 4-entry job queue.
// The back end emits one result per cycle from the head job while out_tready does not stall it;
// an encoded group gives four characters, a decoded quad up to three bytes.
// A group's first result passes through the job queue, the job register and the output register.
// Reset (rst_n low, synchronous) sets mode to encode and empties group and queue.
// in_tready drops only while the job queue is full; out_tready stalls only the back end.

module base64_codec (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,    // [0] mode
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,     // [7:0] data_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,    // [7:0] out_value
  output logic       out_tlast,
  output logic       out_tuser     // [0] error
);
  import b64_pkg::*;

  b64_job_t push_job, head_job;
  logic     push, pop, q_full, q_empty, in_fire;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  b64_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .job_push  (push),
    .job       (push_job)
  );

  b64_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (push_job),
    .pop    (pop),
    .rd_job (head_job),
    .full   (q_full),
    .empty  (q_empty)
  );

  b64_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_job      (head_job),
    .q_empty    (q_empty),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== rtl/b64_front.sv =====
// Front end: mode register and group assembly; emits one job per finished group.
`timescale 1ns / 1ps

module b64_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_fire,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output logic              job_push,
  output b64_pkg::b64_job_t job
);
  import b64_pkg::*;

  logic        mode_r, mode_nxt;
  logic [23:0] bits_r, bits_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic        bad_r, bad_nxt;

  logic [23:0] bits_upd;
  logic [1:0]  pad_upd;
  logic        bad_upd;
  logic [6:0]  dec;
  logic [1:0]  drop;

  always_comb begin
    mode_nxt = mode_r;
    bits_nxt = bits_r;
    cnt_nxt  = cnt_r;
    pad_nxt  = pad_r;
    bad_nxt  = bad_r;
    job_push = 1'b0;
    job      = '0;
    bits_upd = bits_r;
    pad_upd  = pad_r;
    bad_upd  = bad_r;
    dec      = b64_dec_char(in_byte);
    drop     = 2'd0;

    if (cfg_we) begin
      mode_nxt = cfg_wdata;
      bits_nxt = '0;
      cnt_nxt  = '0;
      pad_nxt  = '0;
      bad_nxt  = 1'b0;
    end else if (in_fire) begin
      if (mode_r == MODE_ENC) begin
        case (cnt_r)
          2'd0:    bits_upd[23:16] = bits_r[23:16] | in_byte;
          2'd1:    bits_upd[15:8]  = bits_r[15:8]  | in_byte;
          default: bits_upd[7:0]   = bits_r[7:0]   | in_byte;
        endcase
        if (cnt_r >= 2'd2 || in_last) begin
          job_push    = 1'b1;
          job.enc     = 1'b1;
          job.bits    = bits_upd;
          job.nres_m1 = 2'd3;
          job.nch     = (cnt_r >= 2'd2) ? 3'd4 : {1'b0, cnt_r} + 3'd2;
          job.last    = in_last;
          job.err     = 1'b0;
          bits_nxt = '0;
          cnt_nxt  = '0;
        end else begin
          bits_nxt = bits_upd;
          cnt_nxt  = cnt_r + 2'd1;
        end
      end else begin
        if (in_byte == PAD_CHAR) begin
          dec = 7'd0;
          if (cnt_r == 2'd2) pad_upd[1] = 1'b1;
          if (cnt_r == 2'd3) pad_upd[0] = 1'b1;
        end
        bad_upd = bad_r | dec[6];
        case (cnt_r)
          2'd0:    bits_upd[23:18] = bits_r[23:18] | dec[5:0];
          2'd1:    bits_upd[17:12] = bits_r[17:12] | dec[5:0];
          2'd2:    bits_upd[11:6]  = bits_r[11:6]  | dec[5:0];
          default: bits_upd[5:0]   = bits_r[5:0]   | dec[5:0];
        endcase
        if (cnt_r == 2'd3 || in_last) begin
          job_push = 1'b1;
          job.enc  = 1'b0;
          job.nch  = 3'd0;
          job.last = in_last;
          if (cnt_r != 2'd3) begin
            // incomplete final quad: one zero byte flagged as error
            job.bits    = '0;
            job.nres_m1 = 2'd0;
            job.err     = 1'b1;
          end else begin
            if (in_last) drop = {1'b0, pad_upd[0]} + {1'b0, pad_upd[1]};
            job.bits    = bits_upd;
            job.nres_m1 = 2'd2 - drop;
            job.err     = bad_upd;
          end
          bits_nxt = '0;
          cnt_nxt  = '0;
          pad_nxt  = '0;
          bad_nxt  = 1'b0;
        end else begin
          bits_nxt = bits_upd;
          cnt_nxt  = cnt_r + 2'd1;
          pad_nxt  = pad_upd;
          bad_nxt  = bad_upd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENC;
      bits_r <= '0;
      cnt_r  <= '0;
      pad_r  <= '0;
      bad_r  <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      bits_r <= bits_nxt;
      cnt_r  <= cnt_nxt;
      pad_r  <= pad_nxt;
      bad_r  <= bad_nxt;
    end
  end

endmodule

// ===== rtl/b64_fifo.sv =====
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module b64_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  b64_pkg::b64_job_t wr_job,
  input  logic              pop,
  output b64_pkg::b64_job_t rd_job,
  output logic              full,
  output logic              empty
);
  import b64_pkg::*;

  b64_job_t             mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]     count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full    = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_job;
  end

endmodule

// ===== rtl/b64_back.sv =====
// Back end: walks a queued group and emits its results through an output register.
`timescale 1ns / 1ps

module b64_back (
  input  logic              clk,
  input  logic              rst_n,
  input  b64_pkg::b64_job_t q_job,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast,
  output logic              out_tuser
);
  import b64_pkg::*;

  b64_job_t   job_r, job_nxt;
  logic       job_valid_r, job_valid_nxt;
  logic [1:0] k_r, k_nxt;
  logic       oval_r, oval_nxt;
  logic [7:0] odata_r, odata_nxt;
  logic       olast_r, olast_nxt;
  logic       oerr_r, oerr_nxt;

  logic       emit, done;
  logic [5:0] sext;
  logic [7:0] byte_sel;

  assign emit  = job_valid_r && (!oval_r || out_tready);
  assign done  = emit && (k_r == job_r.nres_m1);
  assign q_pop = !q_empty && (!job_valid_r || done);

  always_comb begin
    case (k_r)
      2'd0:    sext = job_r.bits[23:18];
      2'd1:    sext = job_r.bits[17:12];
      2'd2:    sext = job_r.bits[11:6];
      default: sext = job_r.bits[5:0];
    endcase
    case (k_r)
      2'd0:    byte_sel = job_r.bits[23:16];
      2'd1:    byte_sel = job_r.bits[15:8];
      default: byte_sel = job_r.bits[7:0];
    endcase
  end

  always_comb begin
    job_nxt       = job_r;
    job_valid_nxt = job_valid_r;
    k_nxt         = k_r;
    oval_nxt      = oval_r;
    odata_nxt     = odata_r;
    olast_nxt     = olast_r;
    oerr_nxt      = oerr_r;

    if (oval_r && out_tready) oval_nxt = 1'b0;

    if (emit) begin
      oval_nxt = 1'b1;
      if (job_r.enc)
        odata_nxt = ({1'b0, k_r} < job_r.nch) ? b64_enc_char(sext) : PAD_CHAR;
      else
        odata_nxt = byte_sel;
      olast_nxt = (k_r == job_r.nres_m1) && job_r.last;
      oerr_nxt  = job_r.err;
      k_nxt     = k_r + 2'd1;
    end

    if (done) begin
      job_valid_nxt = 1'b0;
      k_nxt         = 2'd0;
    end

    if (q_pop) begin
      job_nxt       = q_job;
      job_valid_nxt = 1'b1;
      k_nxt         = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      k_r         <= '0;
      oval_r      <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      k_r         <= k_nxt;
      oval_r      <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
    oerr_r  <= oerr_nxt;
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = oerr_r;

  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r |-> k_r <= job_r.nres_m1)
    else $error("result index past end of group");

  a_k_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !job_valid_r |-> k_r == 2'd0)
    else $error("result index not cleared while idle");

  a_enc_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    emit && job_r.enc |=> !oerr_r)
    else $error("error flag on an encoded character");

  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> job_valid_r && k_r == 2'd0)
    else $error("popped job not loaded");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for base64_codec: directed, backpressure and random encode/decode traffic.
`timescale 1ns / 1ps

module tb_top;
  import b64_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 6;      // quiet gap before a mode write
  localparam int TAIL_CYCLES    = 10;
  localparam int WATCHDOG_LIMIT = 2000;   // cycles without any transfer
  localparam int MAX_REPORTS    = 40;
  localparam int ITEMS_PER_PHASE = 50;

  // 64-character alphabet; character k sits at bits [8*(63-k) +: 8]
  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       err;
  } b64_result_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;     // [7:0] data_byte
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;    // [7:0] out_value
  logic       out_tlast;
  logic       out_tuser;    // [0] error

  base64_codec DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // Predicted codec state
  logic [0:0]  cur_mode;
  logic [23:0] grp_bits;
  int          grp_cnt;
  logic [1:0]  pad_seen;   // [1] third char was pad, [0] fourth char was pad
  logic        grp_bad;

  b64_result_t b64_pending[$];
  b64_result_t head_r;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int err_count;
  int items_sent;
  int results_checked;
  int enc_msgs;
  int dec_msgs;
  int cfg_writes;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_group();
    grp_bits = '0;
    grp_cnt  = 0;
    pad_seen = '0;
    grp_bad  = 1'b0;
  endfunction

  function automatic void push_result(input logic [7:0] v, input logic l, input logic e);
    b64_result_t r;
    r.value = v;
    r.last  = l;
    r.err   = e;
    b64_pending = {b64_pending, r};
  endfunction

  // {invalid, sextet}; anything outside the alphabet maps to sextet 0
  function automatic logic [6:0] sextet_lookup(input logic [7:0] c);
    logic [6:0] r;
    int k;
    r = {1'b1, 6'd0};
    for (k = 0; k < 64; k++)
      if (ALPHABET[8*(63-k) +: 8] == c) r = {1'b0, 6'(k)};
    return r;
  endfunction

  function automatic logic [7:0] rand_b64_char();
    int k;
    k = $urandom_range(0, 63);
    return ALPHABET[8*(63-k) +: 8];
  endfunction

  function automatic void b64_predict(input logic [7:0] d, input logic l);
    int slot;
    int k;
    int idx;
    int nb;
    logic [6:0] lk;
    logic [5:0] sx;
    if (cur_mode == MODE_ENC) begin
      slot = (grp_cnt > 2) ? 2 : grp_cnt;
      grp_bits = grp_bits | (24'(d) << (16 - 8 * slot));
      slot++;
      if (slot < 3 && !l) begin
        grp_cnt = slot;
        return;
      end
      // n bytes give n+1 characters, rest padded
      for (k = 0; k < 4; k++) begin
        idx = int'(6'(grp_bits >> (18 - 6 * k)));
        push_result((k < slot + 1) ? ALPHABET[8*(63-idx) +: 8] : PAD_CHAR,
                    (k == 3) ? l : 1'b0, 1'b0);
      end
      clear_group();
    end else begin
      if (d == PAD_CHAR) begin
        sx = '0;
        if (grp_cnt == 2) pad_seen[1] = 1'b1;
        if (grp_cnt == 3) pad_seen[0] = 1'b1;
      end else begin
        lk = sextet_lookup(d);
        sx = lk[5:0];
        if (lk[6]) grp_bad = 1'b1;
      end
      grp_bits = grp_bits | (24'(sx) << (18 - 6 * grp_cnt));
      if (grp_cnt < 3) begin
        if (l) begin
          // short final quad: a single error result
          push_result(8'h00, 1'b1, 1'b1);
          clear_group();
        end else begin
          grp_cnt++;
        end
        return;
      end
      nb = 3;
      if (l) nb = 3 - int'(pad_seen[0]) - int'(pad_seen[1]);
      for (k = 0; k < nb; k++)
        push_result(8'(grp_bits >> (16 - 8 * k)), (k == nb - 1) ? l : 1'b0, grp_bad);
      clear_group();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < MAX_REPORTS)
      $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (b64_pending.size() == 0) begin
        report_mismatch("unexpected result", int'(out_tdata), 0);
      end else begin
        head_r = b64_pending.pop_front();
        results_checked++;
        if (out_tdata !== head_r.value) report_mismatch("out_value", out_tdata, head_r.value);
        if (out_tlast !== head_r.last)  report_mismatch("out_last", out_tlast, head_r.last);
        if (out_tuser !== head_r.err)   report_mismatch("error", out_tuser, head_r.err);
      end
    end
  end

  // Receiver: random stalls, plus a counted hold-off when requested
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long
  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("[%0t] Watchdog: no transfer for %0d cycles, %0d results outstanding",
             $time, WATCHDOG_LIMIT, b64_pending.size());
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Entered and left at a falling edge; tvalid stays high for a back-to-back item.
  task automatic send_item(input logic [7:0] d, input logic l);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    b64_predict(d, l);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_pending();
    in_tvalid <= 1'b0;
    while (b64_pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input logic [0:0] m);
    drain_pending();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_mode = m;
    clear_group();
    cfg_writes++;
  endtask

  task automatic send_encode_msg(input int len);
    int k;
    for (k = 0; k < len; k++)
      send_item(8'($urandom_range(0, 255)), k == len - 1);
    enc_msgs++;
  endtask

  // Mostly well-formed quads, some with a pad tail or a lone third-slot pad; the rest truncated or corrupted
  task automatic send_decode_msg();
    logic [7:0] msg[$];
    int nq;
    int k;
    int kind;
    nq = $urandom_range(1, 3);
    for (k = 0; k < nq * 4; k++) msg = {msg, rand_b64_char()};
    kind = $urandom_range(0, 99);
    if (kind < 72) begin
      case ($urandom_range(0, 3))
        1: msg[nq*4-1] = PAD_CHAR;
        2: begin
          msg[nq*4-2] = PAD_CHAR;
          msg[nq*4-1] = PAD_CHAR;
        end
        3: msg[nq*4-2] = PAD_CHAR;   // pad in third slot only
        default: ;
      endcase
    end else if (kind < 84) begin
      repeat ($urandom_range(1, 3)) void'(msg.pop_back());
    end else if (kind < 94) begin
      msg[$urandom_range(0, nq * 4 - 1)] = 8'($urandom_range(0, 255));
    end else begin
      msg[$urandom_range(0, nq * 4 - 1)] = PAD_CHAR;
    end
    for (k = 0; k < msg.size(); k++) send_item(msg[k], k == msg.size() - 1);
    dec_msgs++;
  endtask

  // Unterminated group, later discarded by a mode write
  task automatic send_fragment();
    int k;
    if (cur_mode == MODE_ENC) begin
      repeat ($urandom_range(1, 2)) send_item(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      for (k = $urandom_range(1, 3); k > 0; k--) send_item(rand_b64_char(), 1'b0);
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
    int start;
    int r;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = items_sent;
    while (items_sent - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        write_mode($urandom_range(0, 1) ? MODE_DEC : MODE_ENC);
      end else if (r < 20) begin
        send_fragment();
        write_mode($urandom_range(0, 1) ? MODE_DEC : MODE_ENC);
      end else if (cur_mode == MODE_ENC) begin
        send_encode_msg($urandom_range(1, 10));
      end else begin
        send_decode_msg();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_encode();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_mode(MODE_ENC);
    send_item(8'h00, 1'b1);                         // one byte, two pads
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b1);                         // two bytes, one pad
    send_item(8'h80, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'hFE, 1'b0);                         // full group, not last
    send_item(8'h7F, 1'b1);
    enc_msgs += 3;
    send_item(8'hA5, 1'b0);                         // dropped by the mode write
  endtask

  task automatic test_directed_decode();
    write_mode(MODE_DEC);
    // pads inside a non-final quad decode as zero
    send_item("T", 1'b0); send_item("Q", 1'b0); send_item("=", 1'b0); send_item("=", 1'b0);
    // pad in the third slot of the final quad still drops a byte
    send_item("T", 1'b0); send_item("W", 1'b0); send_item("=", 1'b0); send_item("E", 1'b1);
    send_item("T", 1'b0); send_item("W", 1'b0); send_item("E", 1'b0); send_item("=", 1'b1);
    // leading pad plus an invalid character: error on every byte
    send_item("=", 1'b0); send_item("*", 1'b0); send_item("A", 1'b0); send_item("/", 1'b1);
    // short final quad
    send_item("T", 1'b0); send_item("W", 1'b1);
    dec_msgs += 4;
  endtask

  task automatic test_backpressure();
    write_mode(MODE_ENC);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left = 150;                                // job queue fills, input stalls
    send_encode_msg(24);
    drain_pending();                                // sender waits for every result
  endtask

  task automatic test_random_traffic();
    run_phase(0, 0, ITEMS_PER_PHASE);
    run_phase(55, 0, ITEMS_PER_PHASE);
    run_phase(0, 55, ITEMS_PER_PHASE);
    run_phase(25, 25, ITEMS_PER_PHASE);
    write_mode(MODE_ENC);
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    hold_left = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    err_count       = 0;
    items_sent      = 0;
    results_checked = 0;
    enc_msgs   = 0;
    dec_msgs   = 0;
    cfg_writes = 0;
    cur_mode   = MODE_ENC;
    clear_group();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_encode();
    test_directed_decode();
    test_backpressure();
    test_random_traffic();

    drain_pending();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d input transfers: %0d encode and %0d decode messages, %0d mode writes",
             items_sent, enc_msgs, dec_msgs, cfg_writes);
    $display("%0d results compared, %0d mismatches", results_checked, err_count);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/b64_pkg.sv
rtl/b64_front.sv
rtl/b64_fifo.sv
rtl/b64_back.sv
rtl/base64_codec.sv
tb/tb_top.sv
